// ----- sv/scp_pkg.sv -----
// shared types, constants and helpers for the segment frustum clipper
package scp_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int T_BITS          = 30;
  localparam int DW              = 50;

  localparam logic [30:0] NEAR_RESET =
    31'(((64'd1 << COORD_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [30:0] FAR_RESET  = 31'(64'd100 << COORD_FRAC_BITS);

  // register indexes
  localparam logic [2:0] REG_CLIP_MODE    = 3'd0;
  localparam logic [2:0] REG_NEAR_DIST    = 3'd1;
  localparam logic [2:0] REG_FAR_DIST     = 3'd2;
  localparam logic [2:0] REG_FOV_VALID    = 3'd3;
  localparam logic [2:0] REG_NORMAL_LEFT  = 3'd4;
  localparam logic [2:0] REG_NORMAL_RIGHT = 3'd5;
  localparam logic [2:0] REG_NORMAL_UP    = 3'd6;
  localparam logic [2:0] REG_NORMAL_DOWN  = 3'd7;

  // plane bit positions in clip_mode and the flags
  localparam int PL_NEAR  = 0;
  localparam int PL_LEFT  = 1;
  localparam int PL_RIGHT = 2;
  localparam int PL_UP    = 3;
  localparam int PL_DOWN  = 4;
  localparam int PL_FAR   = 5;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
  } in_t;

  typedef struct packed {
    logic               kept;
    logic signed [31:0] ca_x;
    logic signed [31:0] ca_y;
    logic signed [31:0] ca_z;
    logic signed [31:0] cb_x;
    logic signed [31:0] cb_y;
    logic signed [31:0] cb_z;
    logic [5:0]         a_flags;
    logic [5:0]         b_flags;
  } out_t;

  // segment as it moves from plane to plane
  typedef struct packed {
    logic             ok;
    logic [2:0][31:0] a;
    logic [2:0][31:0] b;
    logic [5:0]       fa;
    logic [5:0]       fb;
  } seg_t;

  // plane test result handed to the crossing unit
  typedef struct packed {
    seg_t          seg;
    logic          oa;
    logic          ob;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
    logic          set_z;
    logic [31:0]   zval;
    logic [5:0]    mask;
  } xreq_t;

  function automatic logic [32:0] abs33(logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [DW-1:0] abs_dw(logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

endpackage

// ----- sv/scp_depth.sv -----
// depth plane test: inside/outside flags and crossing fraction operands
module scp_depth import scp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        far_i,
  input  logic        plane_en_i,
  input  logic [30:0] dist_i,
  input  logic [5:0]  mask_i,
  input  logic        valid_i,
  input  seg_t        seg_i,
  output logic        valid_o,
  output xreq_t       req_o
);

  logic signed [32:0] az, bz, dz, d_a, b_a;
  logic               act, out_a, out_b;
  xreq_t              req_d, req_q;
  logic               valid_q;

  // compare both depths against the plane
  always_comb begin
    az    = $signed({seg_i.a[2][31], seg_i.a[2]});
    bz    = $signed({seg_i.b[2][31], seg_i.b[2]});
    dz    = $signed({2'b00, dist_i});
    d_a   = dz - az;
    b_a   = bz - az;
    act   = plane_en_i & seg_i.ok;
    out_a = far_i ? (az > dz) : (az < dz);
    out_b = far_i ? (bz > dz) : (bz < dz);
    req_d.seg   = seg_i;
    req_d.oa    = act & out_a;
    req_d.ob    = act & out_b;
    req_d.num   = DW'(abs33(d_a));
    req_d.den   = DW'(abs33(b_a));
    req_d.set_z = 1'b1;
    req_d.zval  = {1'b0, dist_i};
    req_d.mask  = mask_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      req_q <= req_d;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// ----- sv/scp_side.sv -----
// side plane test: dot products with the normal over three stages
module scp_side import scp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        plane_en_i,
  input  logic [47:0] normal_i,
  input  logic [5:0]  mask_i,
  input  logic        valid_i,
  input  seg_t        seg_i,
  output logic        valid_o,
  output xreq_t       req_o
);

  logic signed [47:0] pa_d [3];
  logic signed [47:0] pb_d [3];
  logic signed [47:0] pa_q [3];
  logic signed [47:0] pb_q [3];
  seg_t               seg1_q, seg2_q;
  logic               act1_q, act2_q;
  logic [2:0]         v_q;
  logic signed [DW-1:0] d1_d, d2_d, d1_q, d2_q, dd;
  xreq_t              req_d, req_q;

  // stage 1: component products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_d[k] = $signed(normal_i[16*k +: 16]) * $signed(seg_i.a[k]);
      pb_d[k] = $signed(normal_i[16*k +: 16]) * $signed(seg_i.b[k]);
    end
  end

  // stage 2: sum to dot products
  always_comb begin
    d1_d = DW'(pa_q[0]) + DW'(pa_q[1]) + DW'(pa_q[2]);
    d2_d = DW'(pb_q[0]) + DW'(pb_q[1]) + DW'(pb_q[2]);
  end

  // stage 3: sides and fraction operands
  always_comb begin
    dd          = d1_q - d2_q;
    req_d.seg   = seg2_q;
    req_d.oa    = act2_q & (d1_q > 0);
    req_d.ob    = act2_q & (d2_q > 0);
    req_d.num   = abs_dw(d1_q);
    req_d.den   = abs_dw(dd);
    req_d.set_z = 1'b0;
    req_d.zval  = 32'd0;
    req_d.mask  = mask_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 3'b000;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pa_q   <= pa_d;
      pb_q   <= pb_d;
      seg1_q <= seg_i;
      act1_q <= plane_en_i & seg_i.ok;
      d1_q   <= d1_d;
      d2_q   <= d2_d;
      seg2_q <= seg1_q;
      act2_q <= act1_q;
      req_q  <= req_d;
    end
  end

  assign valid_o = v_q[2];
  assign req_o   = req_q;

endmodule

// ----- sv/scp_cross.sv -----
// crossing unit: pipelined fraction divide, interpolation and endpoint update
module scp_cross import scp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  valid_i,
  input  xreq_t req_i,
  output logic  valid_o,
  output seg_t  seg_o
);

  typedef struct packed {
    xreq_t           x;
    logic            one;
    logic [DW-1:0]   r;
    logic [T_BITS-1:0] q;
  } div_t;

  typedef struct packed {
    xreq_t            x;
    logic [T_BITS:0]  t;
    logic [2:0][32:0] mag;
    logic [2:0]       neg;
  } lrp0_t;

  typedef struct packed {
    xreq_t            x;
    logic [2:0][32:0] off;
    logic [2:0]       neg;
  } lrp1_t;

  div_t          dv_q [T_BITS+1];
  logic [T_BITS:0] dvv_q;
  div_t          dv0_d;
  lrp0_t         l0_d, l0_q;
  lrp1_t         l1_d, l1_q;
  logic [1:0]    lv_q;
  seg_t          seg_d, seg_q;
  logic          sv_q;

  function automatic logic [31:0] sat32(logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -34'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // divider setup: fraction clamps to one when den is zero or num >= den
  always_comb begin
    dv0_d.x   = req_i;
    dv0_d.one = (req_i.den == '0) || (req_i.num >= req_i.den);
    dv0_d.r   = req_i.num;
    dv0_d.q   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else if (adv_i) begin
      dvv_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dv_q[0] <= dv0_d;
    end
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= T_BITS; s++) begin : g_div
    logic [DW:0] r2;
    logic        ge;
    div_t        st_d;

    always_comb begin
      r2      = {dv_q[s-1].r, 1'b0};
      ge      = r2 >= {1'b0, dv_q[s-1].x.den};
      st_d    = dv_q[s-1];
      st_d.r  = ge ? DW'(r2 - {1'b0, dv_q[s-1].x.den}) : DW'(r2);
      st_d.q  = {dv_q[s-1].q[T_BITS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[s] <= 1'b0;
      end else if (adv_i) begin
        dvv_q[s] <= dvv_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dv_q[s] <= st_d;
      end
    end
  end

  // coordinate differences and fraction
  always_comb begin
    logic signed [32:0] diff;
    l0_d.x = dv_q[T_BITS].x;
    l0_d.t = dv_q[T_BITS].one ? (T_BITS+1)'(1) << T_BITS
                              : {1'b0, dv_q[T_BITS].q};
    for (int k = 0; k < 3; k++) begin
      diff = $signed({dv_q[T_BITS].x.seg.b[k][31], dv_q[T_BITS].x.seg.b[k]})
           - $signed({dv_q[T_BITS].x.seg.a[k][31], dv_q[T_BITS].x.seg.a[k]});
      l0_d.mag[k] = abs33(diff);
      l0_d.neg[k] = diff[32];
    end
  end

  // scaled offsets, truncated toward zero
  always_comb begin
    logic [63:0] prod;
    l1_d.x   = l0_q.x;
    l1_d.neg = l0_q.neg;
    for (int k = 0; k < 3; k++) begin
      prod        = 64'(l0_q.mag[k]) * 64'(l0_q.t);
      l1_d.off[k] = prod[62:30];
    end
  end

  // new point and endpoint replacement
  always_comb begin
    logic signed [33:0] c1, sum;
    logic [2:0][31:0]   p;
    seg_d = l1_q.x.seg;
    for (int k = 0; k < 3; k++) begin
      c1   = $signed({{2{l1_q.x.seg.a[k][31]}}, l1_q.x.seg.a[k]});
      sum  = l1_q.neg[k] ? c1 - $signed({1'b0, l1_q.off[k]})
                         : c1 + $signed({1'b0, l1_q.off[k]});
      p[k] = sat32(sum);
    end
    if (l1_q.x.set_z) begin
      p[2] = l1_q.x.zval;
    end
    if (l1_q.x.oa && l1_q.x.ob) begin
      seg_d.ok = 1'b0;
    end else if (l1_q.x.oa) begin
      seg_d.a  = p;
      seg_d.fa = l1_q.x.seg.fa | l1_q.x.mask;
    end else if (l1_q.x.ob) begin
      seg_d.b  = p;
      seg_d.fb = l1_q.x.seg.fb | l1_q.x.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= 2'b00;
      sv_q <= 1'b0;
    end else if (adv_i) begin
      lv_q <= {lv_q[0], dvv_q[T_BITS]};
      sv_q <= lv_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      l0_q  <= l0_d;
      l1_q  <= l1_d;
      seg_q <= seg_d;
    end
  end

  assign valid_o = sv_q;
  assign seg_o   = seg_q;

endmodule

// ----- sv/segment_frustum_clipper.sv -----
// top level: registers, six plane tests in order and the output register
//
//  channel  | signals                              | accepted when
//  ---------+--------------------------------------+---------------------------
//  input    | in_valid_i, in_ready_o, in_data_i    | in_valid_i & in_ready_o
//  output   | out_valid_o, out_ready_i, out_data_o | out_valid_o & out_ready_i
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i      | cfg_we_i
//
// one item per cycle while no result is held; path: input register, near plane,
// four side planes, far plane, output register
// the 30-stage divider of each plane sets the depth
// reset clears valid bits and loads the register defaults
// a held result stalls the whole pipeline; no item is lost or repeated
module segment_frustum_clipper import scp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i
);

  logic [5:0]  mode_q;
  logic [30:0] near_q, far_q;
  logic        fov_q;
  logic [47:0] nl_q, nr_q, nu_q, ndn_q;

  logic        adv;
  logic        near_en;
  seg_t        seg0_q;
  logic        v0_q;
  seg_t        sg [7];
  logic [6:0]  sv;
  xreq_t       xr [6];
  logic [5:0]  xv;
  logic        out_valid_q;
  out_t        out_q, out_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 6'd0;
      near_q <= NEAR_RESET;
      far_q  <= FAR_RESET;
      fov_q  <= 1'b0;
      nl_q   <= 48'd0;
      nr_q   <= 48'd0;
      nu_q   <= 48'd0;
      ndn_q  <= 48'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CLIP_MODE:    mode_q <= cfg_data_i[5:0];
        REG_NEAR_DIST:    near_q <= cfg_data_i[30:0];
        REG_FAR_DIST:     far_q  <= cfg_data_i[30:0];
        REG_FOV_VALID:    fov_q  <= cfg_data_i[0];
        REG_NORMAL_LEFT:  nl_q   <= cfg_data_i;
        REG_NORMAL_RIGHT: nr_q   <= cfg_data_i;
        REG_NORMAL_UP:    nu_q   <= cfg_data_i;
        REG_NORMAL_DOWN:  ndn_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances unless a result is held
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign near_en    = mode_q[PL_NEAR] | (mode_q[PL_LEFT] & mode_q[PL_RIGHT])
                    | (mode_q[PL_UP] & mode_q[PL_DOWN]);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      seg0_q.ok <= 1'b1;
      seg0_q.a  <= {in_data_i.a_z, in_data_i.a_y, in_data_i.a_x};
      seg0_q.b  <= {in_data_i.b_z, in_data_i.b_y, in_data_i.b_x};
      seg0_q.fa <= 6'd0;
      seg0_q.fb <= 6'd0;
    end
  end

  assign sg[0] = seg0_q;
  assign sv[0] = v0_q;

  // near plane
  scp_depth u_near (
    .clk_i, .rst_ni, .adv_i(adv), .far_i(1'b0), .plane_en_i(near_en),
    .dist_i(near_q), .mask_i(6'(1) << PL_NEAR),
    .valid_i(sv[0]), .seg_i(sg[0]), .valid_o(xv[0]), .req_o(xr[0])
  );
  scp_cross u_cross_near (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(xv[0]), .req_i(xr[0]),
    .valid_o(sv[1]), .seg_o(sg[1])
  );

  // side planes
  scp_side u_left (
    .clk_i, .rst_ni, .adv_i(adv), .plane_en_i(fov_q & mode_q[PL_LEFT]),
    .normal_i(nl_q), .mask_i(6'(1) << PL_LEFT),
    .valid_i(sv[1]), .seg_i(sg[1]), .valid_o(xv[1]), .req_o(xr[1])
  );
  scp_cross u_cross_left (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(xv[1]), .req_i(xr[1]),
    .valid_o(sv[2]), .seg_o(sg[2])
  );

  scp_side u_right (
    .clk_i, .rst_ni, .adv_i(adv), .plane_en_i(fov_q & mode_q[PL_RIGHT]),
    .normal_i(nr_q), .mask_i(6'(1) << PL_RIGHT),
    .valid_i(sv[2]), .seg_i(sg[2]), .valid_o(xv[2]), .req_o(xr[2])
  );
  scp_cross u_cross_right (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(xv[2]), .req_i(xr[2]),
    .valid_o(sv[3]), .seg_o(sg[3])
  );

  scp_side u_up (
    .clk_i, .rst_ni, .adv_i(adv), .plane_en_i(fov_q & mode_q[PL_UP]),
    .normal_i(nu_q), .mask_i(6'(1) << PL_UP),
    .valid_i(sv[3]), .seg_i(sg[3]), .valid_o(xv[3]), .req_o(xr[3])
  );
  scp_cross u_cross_up (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(xv[3]), .req_i(xr[3]),
    .valid_o(sv[4]), .seg_o(sg[4])
  );

  scp_side u_down (
    .clk_i, .rst_ni, .adv_i(adv), .plane_en_i(fov_q & mode_q[PL_DOWN]),
    .normal_i(ndn_q), .mask_i(6'(1) << PL_DOWN),
    .valid_i(sv[4]), .seg_i(sg[4]), .valid_o(xv[4]), .req_o(xr[4])
  );
  scp_cross u_cross_down (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(xv[4]), .req_i(xr[4]),
    .valid_o(sv[5]), .seg_o(sg[5])
  );

  // far plane
  scp_depth u_far (
    .clk_i, .rst_ni, .adv_i(adv), .far_i(1'b1), .plane_en_i(mode_q[PL_FAR]),
    .dist_i(far_q), .mask_i(6'(1) << PL_FAR),
    .valid_i(sv[5]), .seg_i(sg[5]), .valid_o(xv[5]), .req_o(xr[5])
  );
  scp_cross u_cross_far (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(xv[5]), .req_i(xr[5]),
    .valid_o(sv[6]), .seg_o(sg[6])
  );

  // result formatting: rejected items read as all zero
  always_comb begin
    out_d = '0;
    if (sg[6].ok) begin
      out_d.kept    = 1'b1;
      out_d.ca_x    = sg[6].a[0];
      out_d.ca_y    = sg[6].a[1];
      out_d.ca_z    = sg[6].a[2];
      out_d.cb_x    = sg[6].b[0];
      out_d.cb_y    = sg[6].b[1];
      out_d.cb_z    = sg[6].b[2];
      out_d.a_flags = sg[6].fa;
      out_d.b_flags = sg[6].fb;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sv[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/scp_checker.sv -----
// port-level checks for the segment frustum clipper, bound to the top level
module scp_checker import scp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // a held result blocks new items
  a_stall_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item taken while result stalled");

  // rejected item carries no coordinates or flags
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.kept |-> out_data_o == '0)
    else $error("rejected item not cleared");

  // a plane moves at most one endpoint
  a_flags_disjoint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.a_flags & out_data_o.b_flags) == 6'd0)
    else $error("plane moved both endpoints");

  // no result during reset
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid in reset");

endmodule

bind segment_frustum_clipper scp_checker u_scp_checker (.*);
